// ----- rtl/core/ub2x_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the 2x upscaler with box mean.
// No dependencies; every other file of the block but ub2x_if imports this package.
package ub2x_pkg;

	localparam int ROW_W        = 12;    // source row counter
	localparam int COL_TAG_W    = 10;    // source column bits that reach the 11-bit column tag
	localparam int OUT_ROW_W    = 13;
	localparam int OUT_COL_W    = 11;
	localparam int CFG_W_W      = 11;
	localparam int CFG_H_W      = 13;
	localparam int HEIGHT_LIMIT = 4096;
	localparam int WIDTH_RESET  = 1024;
	localparam int HEIGHT_RESET = 1024;
	localparam int NPOS         = 9;     // 3x3 output candidates per source pixel
	localparam int SUM_W        = 12;    // weighted sum, at most 9 * 255
	localparam int BOX_RECIP    = 7282;  // ceil(2^16 / 9)
	localparam int RECIP_SHIFT  = 16;
	localparam int PROD_W       = 25;
	localparam int QDEPTH       = 2;
	localparam int QPW          = $clog2(QDEPTH);

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	// One classified source pixel on its way from front to back.
	typedef struct packed {
		logic [ROW_W-1:0]     row;
		logic [COL_TAG_W-1:0] col;
		pix_t                 cur;
		pix_t                 up;
		pix_t                 ul;
		pix_t                 lf;
		logic [NPOS-1:0]      emit;
		logic [NPOS-1:0]      border;
		logic                 frame_last;
	} entry_t;

	typedef enum logic [0:0] {
		CFG_SRC_WIDTH  = 1'b0,
		CFG_SRC_HEIGHT = 1'b1
	} cfg_idx_t;

	// Weighted 3x3 sum from four source samples; the heavy side weighs 2.
	function automatic logic [SUM_W-1:0] box_sum(
		input logic [7:0] ul,
		input logic [7:0] up,
		input logic [7:0] lf,
		input logic [7:0] cur,
		input logic       top_heavy,
		input logic       left_heavy
	);
		logic [9:0] top_s;
		logic [9:0] bot_s;
		top_s = left_heavy ? ({ul, 1'b0} + 10'(up)) : (10'(ul) + {up, 1'b0});
		bot_s = left_heavy ? ({lf, 1'b0} + 10'(cur)) : (10'(lf) + {cur, 1'b0});
		return top_heavy ? (SUM_W'({top_s, 1'b0}) + SUM_W'(bot_s))
		                 : (SUM_W'(top_s) + SUM_W'({bot_s, 1'b0}));
	endfunction

	// Truncated divide by nine through a reciprocal; exact for sums below 2304.
	function automatic logic [7:0] div9(input logic [SUM_W-1:0] s);
		logic [PROD_W-1:0] p;
		p = PROD_W'(s) * PROD_W'(BOX_RECIP);
		return p[RECIP_SHIFT+7:RECIP_SHIFT];
	endfunction

endpackage

// ----- rtl/core/ub2x_if.sv -----
`timescale 1ns / 1ps
// Valid/ready stream interfaces for source pixels and tagged result pixels.
// Depends on nothing; the top level and the front and back modules use them.
interface ub2x_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;

	modport source(output valid, in_red, in_green, in_blue, input ready);
	modport sink(input valid, in_red, in_green, in_blue, output ready);
endinterface

interface ub2x_out_if;
	logic        valid;
	logic        ready;
	logic [12:0] out_row;
	logic [10:0] out_col;
	logic [7:0]  out_red;
	logic [7:0]  out_green;
	logic [7:0]  out_blue;
	logic        run_last;
	logic        frame_done;

	modport source(output valid, out_row, out_col, out_red, out_green, out_blue, run_last,
		frame_done, input ready);
	modport sink(input valid, out_row, out_col, out_red, out_green, out_blue, run_last,
		frame_done, output ready);
endinterface

// ----- rtl/core/upscale_2x_box_average.sv -----
`timescale 1ns / 1ps
// Streaming 2x upscaler: each source pixel (raster order) yields the output pixels it
// completes, two to seven, in raster order of the output. Border outputs copy their source
// pixel, inner ones are the truncated 3x3 mean on the nearest-neighbor grid. The back end
// emits one output per cycle while the receiver is ready; a source pixel inside the frame
// yields four, one on the edge two to seven (seven at the bottom-right corner); the front
// end takes a pixel every cycle until the two-entry queue fills. A pixel's first output
// passes the front register, a queue slot and the output register. Writing either size
// register restarts the frame. Uses ub2x_pkg, ub2x_if, ub2x_front, ub2x_queue, ub2x_back.
module upscale_2x_box_average import ub2x_pkg::*; #(
	parameter int MAX_SRC_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	ub2x_in_if.sink     in_px,
	ub2x_out_if.source  out_px,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CW = $clog2(MAX_SRC_WIDTH);
	localparam int EW = CW + 1;

	logic [CFG_W_W-1:0] width_q;
	logic [CFG_H_W-1:0] height_q;
	logic [EW-1:0]      eff_w;
	logic [CFG_H_W-1:0] eff_h;
	logic               cfg_wr;
	logic               push;
	logic               q_ready;
	logic               pop;
	logic               head_valid;
	entry_t             push_entry;
	entry_t             head;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W_W'(WIDTH_RESET);
			height_q <= CFG_H_W'(HEIGHT_RESET);
		end else if (cfg_wr) begin
			unique case (cfg_idx_t'(paddr[2]))
				CFG_SRC_WIDTH:  width_q  <= pwdata[CFG_W_W-1:0];
				CFG_SRC_HEIGHT: height_q <= pwdata[CFG_H_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx_t'(paddr[2]))
			CFG_SRC_WIDTH:  prdata = 32'(width_q);
			CFG_SRC_HEIGHT: prdata = 32'(height_q);
			default:        prdata = '0;
		endcase
	end

	// Clamp the sizes into their working range.
	always_comb begin
		if (width_q == '0) begin
			eff_w = EW'(1);
		end else if (int'(width_q) > MAX_SRC_WIDTH) begin
			eff_w = EW'(MAX_SRC_WIDTH);
		end else begin
			eff_w = EW'(width_q);
		end
		if (height_q == '0) begin
			eff_h = CFG_H_W'(1);
		end else if (int'(height_q) > HEIGHT_LIMIT) begin
			eff_h = CFG_H_W'(HEIGHT_LIMIT);
		end else begin
			eff_h = height_q;
		end
	end

	ub2x_front #(
		.MAX_SRC_WIDTH(MAX_SRC_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_px     (in_px),
		.eff_w     (eff_w),
		.eff_h     (eff_h),
		.restart   (cfg_wr),
		.push      (push),
		.push_entry(push_entry),
		.q_ready   (q_ready)
	);

	ub2x_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.din     (push_entry),
		.ready   (q_ready),
		.pop     (pop),
		.dout    (head),
		.nonempty(head_valid)
	);

	ub2x_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_valid(head_valid),
		.pop       (pop),
		.out_px    (out_px)
	);

	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");

	a_pop_shows_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (out_px.valid && out_px.run_last))
		else $error("finished pixel did not end its run");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(head_valid && !q_ready && !pop) |=> !q_ready)
		else $error("queue space appeared without a pop");

	a_frame_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_px.valid && out_px.frame_done) |-> out_px.run_last)
		else $error("frame end not on the last output of its pixel");

endmodule

// ----- rtl/core/ub2x_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts source pixels, tracks raster position, keeps the line buffer
// and classifies the 3x3 output candidates of each pixel. Uses ub2x_pkg, ub2x_in_if.
module ub2x_front import ub2x_pkg::*; #(
	parameter int MAX_SRC_WIDTH = 1024,
	localparam int CW = $clog2(MAX_SRC_WIDTH),
	localparam int EW = CW + 1
) (
	input  logic               clk,
	input  logic               arst_n,
	ub2x_in_if.sink            in_px,
	input  logic [EW-1:0]      eff_w,
	input  logic [CFG_H_W-1:0] eff_h,
	input  logic               restart,
	output logic               push,
	output entry_t             push_entry,
	input  logic               q_ready
);

	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	pix_t             last_cur_q;
	pix_t             up_rd_q;
	pix_t             line_mem [MAX_SRC_WIDTH];
	logic             v_s1;
	entry_t           entry_s1;
	entry_t           ent_nxt;
	pix_t             cur;
	logic             accept;
	logic             c_last;
	logic             r_last;

	assign cur    = '{red: in_px.in_red, green: in_px.in_green, blue: in_px.in_blue};
	assign in_px.ready = !v_s1 || q_ready;
	assign accept = in_px.valid && in_px.ready;
	assign push   = v_s1 && q_ready;
	assign c_last = ({1'b0, col_q} + EW'(1)) == eff_w;
	assign r_last = ({1'b0, row_q} + CFG_H_W'(1)) == eff_h;

	// The line buffer read lands in the cycle after accept; splice it in on the way out.
	always_comb begin
		push_entry    = entry_s1;
		push_entry.up = up_rd_q;
	end

	always_comb begin
		logic vi, vj, rb, cb, bd;
		ent_nxt            = '0;
		ent_nxt.row        = row_q;
		ent_nxt.col        = COL_TAG_W'(col_q);
		ent_nxt.cur        = cur;
		ent_nxt.ul         = up_rd_q;
		ent_nxt.lf         = last_cur_q;
		ent_nxt.frame_last = r_last && c_last;
		for (int di = 0; di < 3; di++) begin
			for (int dj = 0; dj < 3; dj++) begin
				vi = (di != 0) || (row_q != '0);
				vj = (dj != 0) || (col_q != '0);
				rb = (di == 1 && row_q == '0) || (di == 2 && r_last);
				cb = (dj == 1 && col_q == '0) || (dj == 2 && c_last);
				bd = rb || cb;
				// border pixels come from the source pixel they copy, inner ones
				// from the pixel that completes their neighborhood
				ent_nxt.emit[di*3+dj]   = vi && vj &&
					(bd ? (di != 0 && dj != 0) : (di != 2 && dj != 2));
				ent_nxt.border[di*3+dj] = bd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			if (restart) begin
				col_q <= '0;
				row_q <= '0;
			end else if (accept) begin
				if (c_last) begin
					col_q <= '0;
					row_q <= r_last ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (push) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_s1   <= ent_nxt;
			last_cur_q <= cur;
		end
	end

	// Read-first line buffer: fetch the pixel above, then overwrite it.
	always_ff @(posedge clk) begin
		if (accept) begin
			up_rd_q         <= line_mem[col_q];
			line_mem[col_q] <= cur;
		end
	end

endmodule

// ----- rtl/core/ub2x_queue.sv -----
`timescale 1ns / 1ps
// Short queue of classified pixels between the front and back ends.
// Uses ub2x_pkg.
module ub2x_queue import ub2x_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t din,
	output logic   ready,
	input  logic   pop,
	output entry_t dout,
	output logic   nonempty
);

	entry_t         slot_q [QDEPTH];
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QPW:0]   cnt_q;

	assign ready    = cnt_q != (QPW+1)'(QDEPTH);
	assign nonempty = cnt_q != '0;
	assign dout     = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QPW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QPW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

endmodule

// ----- rtl/core/ub2x_back.sv -----
`timescale 1ns / 1ps
// Back end: walks the emit mask of the queue head, one output pixel per cycle while the
// receiver is ready, and computes border copies or truncated box means. Uses ub2x_pkg, ub2x_out_if.
module ub2x_back import ub2x_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  entry_t     head,
	input  logic       head_valid,
	output logic       pop,
	ub2x_out_if.source out_px
);

	logic [NPOS-1:0]      taken_q;
	logic [NPOS-1:0]      active;
	logic [NPOS-1:0]      sel;
	logic                 last;
	logic                 di0, di1, dj0, dj1;
	logic                 is_border;
	logic [OUT_ROW_W-1:0] rbase, row_o;
	logic [OUT_COL_W-1:0] cbase, col_o;
	pix_t                 pix_o;
	logic                 fire;
	logic                 valid_q;

	assign active    = head.emit & ~taken_q;
	assign sel       = active & (~active + NPOS'(1));
	assign last      = (active & ~sel) == '0;
	assign di0       = |sel[2:0];
	assign di1       = |sel[5:3];
	assign dj0       = sel[0] | sel[3] | sel[6];
	assign dj1       = sel[1] | sel[4] | sel[7];
	assign is_border = |(sel & head.border);
	assign rbase     = {head.row, 1'b0};
	assign cbase     = {head.col, 1'b0};

	always_comb begin
		row_o = di0 ? rbase - OUT_ROW_W'(1) : (di1 ? rbase : rbase + OUT_ROW_W'(1));
		col_o = dj0 ? cbase - OUT_COL_W'(1) : (dj1 ? cbase : cbase + OUT_COL_W'(1));
		if (is_border) begin
			pix_o = head.cur;
		end else begin
			pix_o.red   = div9(box_sum(head.ul.red, head.up.red, head.lf.red,
				head.cur.red, di0, dj0));
			pix_o.green = div9(box_sum(head.ul.green, head.up.green, head.lf.green,
				head.cur.green, di0, dj0));
			pix_o.blue  = div9(box_sum(head.ul.blue, head.up.blue, head.lf.blue,
				head.cur.blue, di0, dj0));
		end
	end

	assign fire = head_valid && (!valid_q || out_px.ready);
	assign pop  = fire && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (fire) begin
				taken_q <= last ? '0 : (taken_q | sel);
				valid_q <= 1'b1;
			end else if (out_px.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_px.out_row    <= row_o;
			out_px.out_col    <= col_o;
			out_px.out_red    <= pix_o.red;
			out_px.out_green  <= pix_o.green;
			out_px.out_blue   <= pix_o.blue;
			out_px.run_last   <= last;
			out_px.frame_done <= last && head.frame_last;
		end
	end

	assign out_px.valid = valid_q;

endmodule

// ----- tb/sv/upscale_2x_box_average_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for upscale_2x_box_average: drives source pixels and size registers,
// predicts every tagged output pixel and checks them in order under random idling and stalls.
// Depends on ub2x_pkg, ub2x_if and the block's RTL.
module upscale_2x_box_average_tb;
	import ub2x_pkg::*;

	localparam int MAX_W       = 1024;
	localparam int HOLD_CYCLES = 400;
	localparam int LOG_LIMIT   = 40;

	typedef struct packed {
		logic [OUT_ROW_W-1:0] row;
		logic [OUT_COL_W-1:0] col;
		pix_t                 px;
		logic                 run_last;
		logic                 frame_done;
	} out_pix_t;

	// Predicts the output pixels of each source pixel and checks them in arrival order.
	class upscale_checker;
		logic [CFG_W_W-1:0] width_reg;
		logic [CFG_H_W-1:0] height_reg;
		pix_t               line_buf [MAX_W];
		pix_t               ul_px;
		pix_t               lf_px;
		int unsigned        col_cnt;
		int unsigned        row_cnt;
		out_pix_t           pending_outputs [$];
		int                 errors;
		int                 n_pixels;
		int                 n_outputs;
		int                 n_means;
		int                 n_frames;
		int                 n_writes;

		function new();
			width_reg = CFG_W_W'(WIDTH_RESET);
			height_reg = CFG_H_W'(HEIGHT_RESET);
			foreach (line_buf[k]) line_buf[k] = '0;
			restart();
		endfunction

		function void restart();
			ul_px = '0;
			lf_px = '0;
			col_cnt = 0;
			row_cnt = 0;
		endfunction

		function void write_size(cfg_idx_t idx, logic [31:0] value);
			case (idx)
				CFG_SRC_WIDTH: width_reg = value[CFG_W_W-1:0];
				CFG_SRC_HEIGHT: height_reg = value[CFG_H_W-1:0];
				default: ;
			endcase
			n_writes++;
			restart();
		endfunction

		function logic [7:0] chan(pix_t p, int k);
			logic [23:0] b;
			b = p;
			return b[23-8*k -: 8];
		endfunction

		function void accept_pixel(pix_t cur);
			int unsigned we, he, r, c, i, j, wu, wl, s;
			logic [7:0]  mean [3];
			pix_t        up;
			out_pix_t    nxt;
			out_pix_t    held;
			bit          have;
			bit          inner;
			we = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
			he = (height_reg == 0) ? 1 : ((height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg);
			r = (row_cnt >= he) ? he - 1 : row_cnt;
			c = (col_cnt >= we) ? we - 1 : col_cnt;
			up = line_buf[c];
			have = 0;
			held = '0;
			n_pixels++;
			for (int di = 0; di < 3; di++) begin
				if (r == 0 && di == 0) continue;
				i = 2 * r + di - 1;
				if (i >= 2 * he) continue;
				for (int dj = 0; dj < 3; dj++) begin
					if (c == 0 && dj == 0) continue;
					j = 2 * c + dj - 1;
					if (j >= 2 * we) continue;
					inner = !(i == 0 || i == 2 * he - 1 || j == 0 || j == 2 * we - 1);
					if (!inner) begin
						// border pixels copy their own source pixel
						if ((i >> 1) != r || (j >> 1) != c) continue;
						nxt.px = cur;
					end else begin
						if (((i + 1) >> 1) != r || ((j + 1) >> 1) != c) continue;
						wu = (i + 1 == 2 * r) ? 2 : 1;
						wl = (j + 1 == 2 * c) ? 2 : 1;
						for (int k = 0; k < 3; k++) begin
							s = wu * (wl * chan(ul_px, k) + (3 - wl) * chan(up, k))
								+ (3 - wu) * (wl * chan(lf_px, k) + (3 - wl) * chan(cur, k));
							mean[k] = 8'(s / 9);
						end
						nxt.px = {mean[0], mean[1], mean[2]};
						n_means++;
					end
					nxt.row = i[OUT_ROW_W-1:0];
					nxt.col = j[OUT_COL_W-1:0];
					nxt.run_last = 1'b0;
					nxt.frame_done = 1'b0;
					// hold back one so the last of the run can be flagged
					if (have) pending_outputs.push_back(held);
					held = nxt;
					have = 1;
				end
			end
			if (have) begin
				held.run_last = 1'b1;
				held.frame_done = (r == he - 1 && c == we - 1);
				pending_outputs.push_back(held);
			end
			ul_px = up;
			line_buf[c] = cur;
			lf_px = cur;
			if (c + 1 >= we) begin
				col_cnt = 0;
				ul_px = '0;
				lf_px = '0;
				if (r + 1 >= he) begin
					row_cnt = 0;
					n_frames++;
				end else begin
					row_cnt = r + 1;
				end
			end else begin
				col_cnt = c + 1;
				row_cnt = r;
			end
		endfunction

		function void compare(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				if (errors <= LOG_LIMIT)
					$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			end
		endfunction

		function void check_output(out_pix_t got);
			out_pix_t want;
			n_outputs++;
			if (pending_outputs.size() == 0) begin
				errors++;
				if (errors <= LOG_LIMIT)
					$display("%0t: unexpected output, expected none, actual row %0d col %0d rgb %h",
						$time, got.row, got.col, got.px);
				return;
			end
			want = pending_outputs.pop_front();
			compare("out_row", want.row, got.row);
			compare("out_col", want.col, got.col);
			compare("out_red", want.px.red, got.px.red);
			compare("out_green", want.px.green, got.px.green);
			compare("out_blue", want.px.blue, got.px.blue);
			compare("run_last", want.run_last, got.run_last);
			compare("frame_done", want.frame_done, got.frame_done);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	ub2x_in_if  in_if();
	ub2x_out_if out_if();

	upscale_checker sb = new();

	int src_idle_pct;
	int sink_stall_pct;
	int hold_req;
	int hold_seen;
	int hold_left;

	upscale_2x_box_average u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_px  (in_if.sink),
		.out_px (out_if.source),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	always #5 clk = ~clk;

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		out_if.ready = 1'b0;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_if.ready <= 1'b0;
			end else begin
				out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : monitor
		out_pix_t seen;
		if (arst_n && out_if.valid && out_if.ready) begin
			seen.row = out_if.out_row;
			seen.col = out_if.out_col;
			seen.px = {out_if.out_red, out_if.out_green, out_if.out_blue};
			seen.run_last = out_if.run_last;
			seen.frame_done = out_if.frame_done;
			sb.check_output(seen);
		end
	end

	initial begin
		#5_000_000;
		$display("%0t: timeout, %0d outputs still expected", $time, sb.pending_outputs.size());
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic send_pixel(pix_t p);
		while ($urandom_range(99) < src_idle_pct) begin
			in_if.valid <= 1'b0;
			@(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.in_red <= p.red;
		in_if.in_green <= p.green;
		in_if.in_blue <= p.blue;
		@(posedge clk);
		while (!in_if.ready) @(posedge clk);
		sb.accept_pixel(p);
	endtask

	task automatic send_random(int n);
		repeat (n) send_pixel(pix_t'(24'($urandom)));
	endtask

	task automatic drain();
		in_if.valid <= 1'b0;
		while (sb.pending_outputs.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.write_size(idx, value);
	endtask

	task automatic set_sizes(int w, int h);
		write_reg(CFG_SRC_WIDTH, w);
		write_reg(CFG_SRC_HEIGHT, h);
	endtask

	task automatic set_idling(int src_pct, int sink_pct);
		src_idle_pct = src_pct;
		sink_stall_pct <= sink_pct;
	endtask

	// mostly small frames so that many wrap; now and then an extreme or large size
	task automatic random_sizes();
		int w;
		int h;
		case ($urandom_range(9))
			0: w = 0;
			1: w = MAX_W;
			2: w = 2047;
			3: w = $urandom_range(7, MAX_W);
			default: w = $urandom_range(1, 6);
		endcase
		case ($urandom_range(9))
			0: h = 0;
			1: h = HEIGHT_LIMIT;
			2: h = 8191;
			default: h = $urandom_range(1, 5);
		endcase
		write_reg(CFG_SRC_WIDTH, w);
		if ($urandom_range(9) < 7) write_reg(CFG_SRC_HEIGHT, h);
	endtask

	initial begin
		pix_t corner_px [8];
		corner_px = '{
			'{8'h00, 8'h00, 8'h00}, '{8'hff, 8'hff, 8'hff}, '{8'haa, 8'h55, 8'haa},
			'{8'h55, 8'haa, 8'h55}, '{8'hff, 8'h00, 8'hff}, '{8'h00, 8'hff, 8'h00},
			'{8'h01, 8'h80, 8'h7f}, '{8'hfe, 8'h7f, 8'h80}
		};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_if.valid = 1'b0;
		in_if.in_red = '0;
		in_if.in_green = '0;
		in_if.in_blue = '0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		hold_req = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 3x2 frame of extreme values, then the start of the next frame
		set_sizes(3, 2);
		for (int k = 0; k < 8; k++) send_pixel(corner_px[k]);
		drain();
		// single-pixel frames: smallest size, then zero sizes acting as one
		set_sizes(1, 1);
		send_pixel(corner_px[1]);
		send_pixel(corner_px[6]);
		drain();
		set_sizes(0, 0);
		send_pixel(corner_px[7]);
		drain();
		// sizes above the limits clamp
		set_sizes(2047, 8191);
		for (int k = 0; k < 3; k++) send_pixel(corner_px[k + 2]);
		drain();
		set_sizes(MAX_W, HEIGHT_LIMIT);
		send_pixel(corner_px[1]);
		send_pixel(corner_px[0]);
		drain();
		// narrow and tall: inner means against full-scale neighbors
		set_sizes(2, 3);
		for (int k = 0; k < 6; k++) send_pixel(corner_px[(k * 3) % 8]);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: set_idling(0, 0);
				1: set_idling(82, 0);
				2: set_idling(0, 82);
				default: set_idling(38, 38);
			endcase
			repeat (2) begin
				drain();
				random_sizes();
				send_random($urandom_range(14, 18));
			end
		end

		// long receiver hold-off while the sender keeps offering requests
		drain();
		set_idling(0, 0);
		set_sizes($urandom_range(2, 5), $urandom_range(2, 4));
		hold_req <= hold_req + 1;
		send_random(20);

		drain();
		repeat (20) @(posedge clk);
		if (sb.pending_outputs.size() != 0) begin
			$display("%0t: %0d expected outputs never arrived", $time, sb.pending_outputs.size());
			sb.errors += sb.pending_outputs.size();
		end
		$display("Covered %0d source pixels and %0d output pixels, %0d of them box means,",
			sb.n_pixels, sb.n_outputs, sb.n_means);
		$display("across %0d completed frames and %0d size register writes.", sb.n_frames,
			sb.n_writes);
		if (sb.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/ub2x_pkg.sv
rtl/core/ub2x_if.sv
rtl/core/ub2x_front.sv
rtl/core/ub2x_queue.sv
rtl/core/ub2x_back.sv
rtl/core/upscale_2x_box_average.sv
tb/sv/upscale_2x_box_average_tb.sv
